>>> design/pucd_pkg.sv
`default_nettype none

package pucd_pkg;

    // Default table size and the index limit set by the 8-bit index field.
    localparam int TABLE_ENTRIES_DEF = 256;
    localparam int INDEX_LIMIT       = 256;

    // Field widths.
    localparam int CMD_W    = 2;
    localparam int COLOR_W  = 32;
    localparam int INDEX_W  = 8;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 9;

    // Only the RGB part of a color takes part in the match.
    localparam int RGB_W = 24;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_READ   = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_FOUND    = 2'd0,
        ST_APPENDED = 2'd1,
        ST_OVERFLOW = 2'd2,
        ST_DONE     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_READ_WAIT,
        S_EMIT
    } state_t;

endpackage

`default_nettype wire

>>> design/palette_union_color_dedup.sv
`default_nettype none

// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall  command, color, read_index
// output    out        out_valid/out_stall  color_index, status, entry_color, used_count
//
// An insert scans the stored colors one per cycle through the single RAM read
// port before the next transaction can be taken. A clear, an unused command or a
// read of entry zero or beyond the count goes straight from idle to emit; a read
// of a stored entry first waits in S_READ_WAIT for the RAM data.
// Reset empties the table at once (count back to 1); the RAM needs no clearing.
// A stalled result waits in the output register; a new transaction is taken as
// soon as the sequencer has handed its result over.

module palette_union_color_dedup
    import pucd_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [CMD_W-1:0]    command,
    input  wire logic [COLOR_W-1:0]  color,
    input  wire logic [INDEX_W-1:0]  read_index,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [INDEX_W-1:0]       color_index,
    output logic [STATUS_W-1:0]      status,
    output logic [COLOR_W-1:0]       entry_color,
    output logic [COUNT_W-1:0]       used_count
);

    // Usable depth: indices are 8 bits, so the table never exceeds 256 entries.
    localparam int CAP   = (TABLE_ENTRIES < INDEX_LIMIT) ? TABLE_ENTRIES : INDEX_LIMIT;
    localparam int IDX_W = $clog2(CAP);
    localparam int NF_W  = $clog2(CAP + 1);

    state_t               state_reg,       state_next;
    logic [NF_W-1:0]      next_free_reg,   next_free_next;
    logic [NF_W-1:0]      scan_reg,        scan_next;
    logic                 cmp_vld_reg,     cmp_vld_next;
    logic [IDX_W-1:0]     cmp_idx_reg,     cmp_idx_next;
    logic [COLOR_W-1:0]   color_reg,       color_next;
    logic [IDX_W-1:0]     res_index_reg,   res_index_next;
    status_t              res_status_reg,  res_status_next;
    logic [COLOR_W-1:0]   res_entry_reg,   res_entry_next;
    logic                 out_valid_reg,   out_valid_next;
    logic [INDEX_W-1:0]   out_index_reg,   out_index_next;
    logic [STATUS_W-1:0]  out_status_reg,  out_status_next;
    logic [COLOR_W-1:0]   out_entry_reg,   out_entry_next;
    logic [COUNT_W-1:0]   out_count_reg,   out_count_next;

    logic                 ram_wr_en;
    logic [IDX_W-1:0]     ram_wr_addr;
    logic                 ram_rd_en;
    logic [IDX_W-1:0]     ram_rd_addr;
    logic [COLOR_W-1:0]   ram_rd_data;

    logic                 out_free;
    logic                 rd_hit;
    logic                 rgb_match;

    pucd_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (CAP)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (color_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Hand a result over when the output register is empty or being drained.
    assign out_free  = !out_valid_reg || !out_stall;
    // A read only touches entries that hold a colour since the last clear.
    assign rd_hit    = (read_index != '0) && (COUNT_W'(read_index) < COUNT_W'(next_free_reg));
    assign rgb_match = ram_rd_data[RGB_W-1:0] == color_reg[RGB_W-1:0];

    assign in_stall  = state_reg != S_IDLE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            next_free_reg <= NF_W'(1);
            cmp_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            next_free_reg <= next_free_next;
            cmp_vld_reg   <= cmp_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg       <= scan_next;
        cmp_idx_reg    <= cmp_idx_next;
        color_reg      <= color_next;
        res_index_reg  <= res_index_next;
        res_status_reg <= res_status_next;
        res_entry_reg  <= res_entry_next;
        out_index_reg  <= out_index_next;
        out_status_reg <= out_status_next;
        out_entry_reg  <= out_entry_next;
        out_count_reg  <= out_count_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        next_free_next  = next_free_reg;
        scan_next       = scan_reg;
        cmp_vld_next    = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        color_next      = color_reg;
        res_index_next  = res_index_reg;
        res_status_next = res_status_reg;
        res_entry_next  = res_entry_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_index_next  = out_index_reg;
        out_status_next = out_status_reg;
        out_entry_next  = out_entry_reg;
        out_count_next  = out_count_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = next_free_reg[IDX_W-1:0];
        ram_rd_en       = 1'b0;
        ram_rd_addr     = scan_reg[IDX_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    color_next      = color;
                    res_index_next  = '0;
                    res_status_next = ST_DONE;
                    res_entry_next  = '0;
                    state_next      = S_EMIT;
                    unique case (cmd_t'(command))
                        CMD_CLEAR:
                        begin
                            next_free_next = NF_W'(1);
                        end
                        CMD_INSERT:
                        begin
                            scan_next  = NF_W'(1);
                            state_next = S_SEARCH;
                        end
                        CMD_READ:
                        begin
                            if (rd_hit)
                            begin
                                ram_rd_en   = 1'b1;
                                ram_rd_addr = read_index[IDX_W-1:0];
                                state_next  = S_READ_WAIT;
                            end
                        end
                        CMD_NOP:
                        begin
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_SEARCH:
            begin
                // Compare last cycle's entry while fetching the next one.
                priority if (cmp_vld_reg && rgb_match)
                begin
                    res_index_next  = cmp_idx_reg;
                    res_status_next = ST_FOUND;
                    state_next      = S_EMIT;
                end
                else if (scan_reg < next_free_reg)
                begin
                    ram_rd_en    = 1'b1;
                    scan_next    = scan_reg + NF_W'(1);
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = scan_reg[IDX_W-1:0];
                end
                else if (!cmp_vld_reg)
                begin
                    // No match anywhere: append, or refuse when full.
                    state_next = S_EMIT;
                    if (next_free_reg >= NF_W'(CAP))
                    begin
                        res_index_next  = '0;
                        res_status_next = ST_OVERFLOW;
                    end
                    else
                    begin
                        ram_wr_en       = 1'b1;
                        res_index_next  = next_free_reg[IDX_W-1:0];
                        res_status_next = ST_APPENDED;
                        next_free_next  = next_free_reg + NF_W'(1);
                    end
                end
                else
                begin
                    // Last compare missed; let it drain before deciding.
                end
            end

            S_READ_WAIT:
            begin
                res_entry_next = ram_rd_data;
                state_next     = S_EMIT;
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_index_next  = INDEX_W'(res_index_reg);
                    out_status_next = res_status_reg;
                    out_entry_next  = res_entry_reg;
                    out_count_next  = COUNT_W'(next_free_reg);
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid   = out_valid_reg;
    assign color_index = out_index_reg;
    assign status      = out_status_reg;
    assign entry_color = out_entry_reg;
    assign used_count  = out_count_reg;

    // The count never drops below the reserved entry nor exceeds the table.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (next_free_reg != '0) && (next_free_reg <= NF_W'(CAP)))
        else $error("next free index out of range");

    // A found index points at an occupied entry.
    a_found_in_use: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_FOUND)) |->
            ((color_index != '0) && (COUNT_W'(color_index) < used_count)))
        else $error("found index outside occupied entries");

    // An appended colour sits just below the new count.
    a_append_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_APPENDED)) |->
            ((COUNT_W'(color_index) + COUNT_W'(1)) == used_count))
        else $error("appended index does not match count");

    // Overflow is reported only with a full table.
    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_OVERFLOW)) |-> (used_count == COUNT_W'(CAP)))
        else $error("overflow with free entries left");

    // The table is written only when a search has ended without a match.
    a_write_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        ram_wr_en |-> ((state_reg == S_SEARCH) && !cmp_vld_reg && (scan_reg >= next_free_reg)))
        else $error("table write outside append");

endmodule

`default_nettype wire

>>> design/pucd_ram.sv
`default_nettype none

module pucd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire
